[rtl/ultrasonic_echo_ranger_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the echo ranger
// Shared property wrappers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define UER_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the echo ranger front end, queue and back end.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int COUNT_BITS_DEFAULT = 23;
  localparam int QUEUE_DEPTH        = 4;

  // Configuration register map
  localparam int CFG_INDEX_BITS   = 1;
  localparam int CFG_DATA_BITS    = 23;
  localparam int TRIG_WIDTH_BITS  = 8;
  localparam int TIMEOUT_BITS     = 23;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 1'b1;
  localparam logic [TRIG_WIDTH_BITS-1:0] TRIG_WIDTH_RESET = 8'd10;
  localparam logic [TIMEOUT_BITS-1:0]    TIMEOUT_RESET    = 23'd5000000;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ECHO  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Distance = width * SCALE_NUM / SCALE_DEN, saturated to DIST_BITS
  localparam int DIST_BITS = 21;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam longint unsigned SCALE_NUM = 64'd3403;
  localparam longint unsigned SCALE_DEN = 64'd20000;
  localparam longint unsigned DIST_LIMIT = 64'd1 << DIST_BITS;

  // Widths at or above this saturate the distance; below it they fit WC_BITS.
  localparam longint unsigned SAT_WIDTH_L =
    (DIST_LIMIT * SCALE_DEN + SCALE_NUM - 64'd1) / SCALE_NUM;
  localparam logic [31:0] SAT_WIDTH = 32'(SAT_WIDTH_L);
  localparam int WC_BITS = 24;

  // Reciprocal: floor(w*NUM/DEN) == (w*RECIP) >> RECIP_SHIFT for w < 2**WC_BITS
  localparam int RECIP_SHIFT   = 39;
  localparam int RECIP_BITS    = 37;
  localparam int RECIP_SPLIT   = 19;
  localparam int RECIP_HI_BITS = RECIP_BITS - RECIP_SPLIT;
  localparam longint unsigned RECIP_L =
    ((SCALE_NUM << RECIP_SHIFT) + SCALE_DEN - 64'd1) / SCALE_DEN;
  localparam logic [RECIP_HI_BITS-1:0] RECIP_HI = RECIP_HI_BITS'(RECIP_L >> RECIP_SPLIT);
  localparam logic [RECIP_SPLIT-1:0]   RECIP_LO = RECIP_SPLIT'(RECIP_L);

  // One classified tick handed from the front end to the back end
  typedef struct packed {
    logic               trig;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic               ok;
    logic               sat;
    logic [WC_BITS-1:0] width;
  } uer_entry_t;

endpackage

[rtl/ultrasonic_echo_ranger_top.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Trigger/echo range measurement driven by one input beat per microsecond.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per microsecond tick with the
//   sampled echo_level and a start_req. Output channel (out_valid/out_ready):
//   exactly one beat per input beat, in order, with trigger_level, busy_res,
//   done_res, status and the last good distance_mm.
//   Throughput: one beat per cycle, sustained while out_ready stays high.
//   An accepted beat passes the queue slot, the partial-product stage, then
//   sum and output register of the back end before out_valid.
//   The front end classifies each tick in the cycle it is accepted and hands
//   it to a 4-entry queue; when out_ready is low the back end holds its beat,
//   the queue fills, and in_ready drops once 4 beats are waiting.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 trigger
//   width, 1 timeout ticks) on the same edge; write only while idle.
//   Reset: block idle, trigger width 10, timeout 5000000 ticks (clamped to
//   the counter range), distance 0; no clearing pass.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      echo_level,
  input  logic                      start_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      trigger_level,
  output logic                      busy_res,
  output logic                      done_res,
  output logic [1:0]                status,
  output logic [DIST_BITS-1:0]      distance_mm
);

  logic       q_ready;   // queue has room: front may take a beat
  logic       push;
  uer_entry_t push_entry;
  logic       q_valid;
  logic       q_pop;
  uer_entry_t q_entry;

  // Accept a tick only when its classified beat has a queue slot.
  assign in_ready = q_ready;

  // Front end: state machine, counters, timeout and config registers.
  uer_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .echo_level (echo_level),
    .start_req  (start_req),
    .q_ready    (q_ready),
    .push       (push),
    .entry      (push_entry)
  );

  // Decoupling queue: lets the front keep classifying during output stalls.
  uer_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // Back end: distance arithmetic and the output register.
  uer_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .status        (status),
    .distance_mm   (distance_mm)
  );

endmodule

[rtl/uer_front.sv]
// ----------------------------------------------------------------------------
// uer_front
// Per-tick measurement state machine and configuration registers.
// ----------------------------------------------------------------------------
module uer_front
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      echo_level,
  input  logic                      start_req,
  input  logic                      q_ready,
  output logic                      push,
  output uer_entry_t                entry
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  function automatic logic [COUNT_BITS-1:0] clamp_timeout(
    input logic [TIMEOUT_BITS-1:0] v
  );
    logic [COUNT_BITS-1:0] r;
    if (v == '0) begin
      r = COUNT_BITS'(1);
    end else if (32'(v) > 32'(CNT_MAX)) begin
      r = CNT_MAX;
    end else begin
      r = COUNT_BITS'(v);
    end
    return r;
  endfunction

  phase_t                     phase, phase_next;
  logic [TRIG_WIDTH_BITS-1:0] trig_count, trig_count_next;
  logic [COUNT_BITS-1:0]      elapsed, elapsed_next;
  logic [COUNT_BITS-1:0]      echo_width, echo_width_next;
  logic [TRIG_WIDTH_BITS-1:0] trig_width;
  logic [COUNT_BITS-1:0]      timeout_lim;

  logic [COUNT_BITS-1:0] elapsed_inc, width_inc;
  logic                  hit;
  logic                  trig, done, ok;
  logic [1:0]            st;

  assign push = in_valid && q_ready;

  assign elapsed_inc = (elapsed == CNT_MAX) ? elapsed : elapsed + COUNT_BITS'(1);
  assign width_inc   = (echo_width == CNT_MAX) ? echo_width : echo_width + COUNT_BITS'(1);
  assign hit         = elapsed_inc >= timeout_lim;

  always_comb begin
    phase_next      = phase;
    trig_count_next = trig_count;
    elapsed_next    = elapsed;
    echo_width_next = echo_width;
    trig            = 1'b0;
    done            = 1'b0;
    ok              = 1'b0;
    st              = ST_OK;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next      = PH_TRIG;
          trig_count_next = TRIG_WIDTH_BITS'(1);
          trig            = 1'b1;
        end
      end
      PH_TRIG: begin
        if (trig_count >= trig_width) begin
          phase_next   = PH_WAIT;
          elapsed_next = '0;
        end else begin
          trig_count_next = trig_count + TRIG_WIDTH_BITS'(1);
          trig            = 1'b1;
        end
      end
      PH_WAIT: begin
        elapsed_next = elapsed_inc;
        if (echo_level) begin
          phase_next      = PH_MEAS;
          echo_width_next = COUNT_BITS'(1);
          if (hit) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
            st         = ST_TOO_LONG;
          end
        end else if (hit) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
          st         = ST_NO_ECHO;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          elapsed_next    = elapsed_inc;
          echo_width_next = width_inc;
          if (hit) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
            st         = ST_TOO_LONG;
          end
        end else begin
          // echo fell: report the width held so far
          phase_next = PH_IDLE;
          done       = 1'b1;
          ok         = 1'b1;
          st         = ST_OK;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    entry.trig   = trig;
    entry.busy   = (phase_next != PH_IDLE);
    entry.done   = done;
    entry.status = st;
    entry.ok     = ok;
    entry.sat    = (32'(echo_width) >= SAT_WIDTH);
    entry.width  = WC_BITS'(echo_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      trig_count  <= '0;
      elapsed     <= '0;
      echo_width  <= '0;
      trig_width  <= TRIG_WIDTH_RESET;
      timeout_lim <= clamp_timeout(TIMEOUT_RESET);
    end else begin
      if (push) begin
        phase      <= phase_next;
        trig_count <= trig_count_next;
        elapsed    <= elapsed_next;
        echo_width <= echo_width_next;
      end
      if (cfg_we) begin
        if (cfg_index == REG_TRIGGER_WIDTH) begin
          trig_width <= TRIG_WIDTH_BITS'(cfg_data);
        end else if (cfg_index == REG_TIMEOUT_TICKS) begin
          timeout_lim <= clamp_timeout(TIMEOUT_BITS'(cfg_data));
        end
      end
    end
  end

`include "ultrasonic_echo_ranger_top_assert.svh"

  `UER_ASSERT_NEXT(a_done_to_idle, push && entry.done, phase == PH_IDLE, "finish left block busy")
  `UER_ASSERT_IMPL(a_meas_width, phase == PH_MEAS, echo_width != '0, "measuring with zero width")

endmodule

[rtl/uer_queue.sv]
// ----------------------------------------------------------------------------
// uer_queue
// Short FIFO of classified ticks between the front end and the back end.
// ----------------------------------------------------------------------------
module uer_queue
  import uer_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  uer_entry_t push_entry,
  output logic       ready,
  input  logic       pop,
  output logic       q_valid,
  output uer_entry_t q_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uer_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready   = (count != CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`include "ultrasonic_echo_ranger_top_assert.svh"

  `UER_ASSERT_IMPL(a_q_empty_ptrs, count == '0, wr_ptr == rd_ptr, "empty queue with pointers apart")

endmodule

[rtl/uer_back.sv]
// ----------------------------------------------------------------------------
// uer_back
// Distance pipeline: split reciprocal multiply, then sum, saturate and output.
// ----------------------------------------------------------------------------
module uer_back
  import uer_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  uer_entry_t           q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 trigger_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [1:0]           status,
  output logic [DIST_BITS-1:0] distance_mm
);

  localparam int PH_BITS   = WC_BITS + RECIP_HI_BITS;
  localparam int PL_BITS   = WC_BITS + RECIP_SPLIT;
  localparam int PROD_BITS = WC_BITS + RECIP_BITS;

  logic                 s1_valid;
  logic                 s1_trig, s1_busy, s1_done, s1_ok, s1_sat;
  logic [1:0]           s1_status;
  logic [PH_BITS-1:0]   s1_ph;
  logic [PL_BITS-1:0]   s1_pl;

  logic                 out_take, s1_ready, out_load;
  logic [PROD_BITS-1:0] prod_sum;
  logic [DIST_BITS-1:0] dist_new;

  assign out_take = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_take;
  assign q_pop    = q_valid && s1_ready;
  assign out_load = s1_valid && out_take;

  assign prod_sum = (PROD_BITS'(s1_ph) << RECIP_SPLIT) + PROD_BITS'(s1_pl);
  assign dist_new = s1_sat ? DIST_MAX : prod_sum[RECIP_SHIFT +: DIST_BITS];

  // Stage 1: partial products of width times reciprocal
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_trig   <= q_entry.trig;
      s1_busy   <= q_entry.busy;
      s1_done   <= q_entry.done;
      s1_status <= q_entry.status;
      s1_ok     <= q_entry.ok;
      s1_sat    <= q_entry.sat;
      s1_ph     <= PH_BITS'(q_entry.width) * PH_BITS'(RECIP_HI);
      s1_pl     <= PL_BITS'(q_entry.width) * PL_BITS'(RECIP_LO);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      trigger_level <= s1_trig;
      busy_res      <= s1_busy;
      done_res      <= s1_done;
      status        <= s1_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      distance_mm <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_valid;
      end
      if (out_take) begin
        out_valid <= s1_valid;
      end
      // distance_mm doubles as the last good distance
      if (out_load && s1_ok) begin
        distance_mm <= dist_new;
      end
    end
  end

`include "ultrasonic_echo_ranger_top_assert.svh"

  `UER_ASSERT_NEXT(a_dist_hold, !(out_load && s1_ok), distance_mm == $past(distance_mm), "distance moved without a good finish")

endmodule

[test/ultrasonic_echo_ranger_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top_test
// Self-checking bench for the echo ranger. Ticks go in over a valid/ready
// channel while a tick-by-tick model predicts the trigger, busy, done,
// status and distance of every output beat. A checker compares each beat
// with the oldest prediction. Reset defaults, directed corner cases, extreme
// settings, random measurement traffic under several idling mixes and a long
// output hold-off run in turn.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top_test;
  import uer_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEFAULT;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP = 100;

  typedef enum logic [1:0] {
    RANGER_IDLE,
    RANGER_TRIGGER,
    RANGER_WAIT_RISE,
    RANGER_MEASURE
  } ranger_phase_t;

  // One predicted output beat.
  typedef struct {
    logic                 trig;
    logic                 busy;
    logic                 done;
    logic [1:0]           status;
    logic [DIST_BITS-1:0] distance;
  } tick_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      echo_level = 1'b0;
  logic                      start_req = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      trigger_level;
  logic                      busy_res;
  logic                      done_res;
  logic [1:0]                status;
  logic [DIST_BITS-1:0]      distance_mm;

  ultrasonic_echo_ranger_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .echo_level    (echo_level),
    .start_req     (start_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .status        (status),
    .distance_mm   (distance_mm)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Tick model: configuration mirror and measurement state
  // --------------------------------------------------------------------------
  logic [TRIG_WIDTH_BITS-1:0] m_trig_width = TRIG_WIDTH_RESET;
  logic [TIMEOUT_BITS-1:0]    m_timeout    = TIMEOUT_RESET;
  ranger_phase_t              m_phase      = RANGER_IDLE;
  logic [TRIG_WIDTH_BITS-1:0] m_trig_cnt   = '0;
  logic [CNT_W-1:0]           m_elapsed    = '0;
  logic [CNT_W-1:0]           m_echo_width = '0;
  logic [DIST_BITS-1:0]       m_last_dist  = '0;

  // Predicted beats, oldest first.
  tick_result_t pending_ticks[$];

  int unsigned items_sent = 0;
  int unsigned out_beats = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Idling controls; set_idling writes them only at the falling edge so the
  // rising-edge processes never race on them.
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // A zero timeout acts as one tick.
  function automatic logic past_timeout();
    logic [CNT_W-1:0] lim;
    lim = (m_timeout == '0) ? CNT_W'(1) : CNT_W'(m_timeout);
    return m_elapsed >= lim;
  endfunction

  // Advance the model by one accepted tick and queue the beat it produces.
  task automatic ranger_model_step(input logic echo, input logic start);
    tick_result_t     r;
    longint unsigned  scaled;
    r.trig   = 1'b0;
    r.done   = 1'b0;
    r.status = ST_OK;
    case (m_phase)
      RANGER_IDLE: begin
        if (start) begin
          m_phase    = RANGER_TRIGGER;
          m_trig_cnt = 8'd1;
          r.trig     = 1'b1;
        end
      end
      RANGER_TRIGGER: begin
        // Echo is ignored here; a zero width ends after one tick.
        if (m_trig_cnt >= m_trig_width) begin
          m_phase   = RANGER_WAIT_RISE;
          m_elapsed = '0;
        end else begin
          m_trig_cnt = m_trig_cnt + 8'd1;
          r.trig     = 1'b1;
        end
      end
      RANGER_WAIT_RISE: begin
        m_elapsed = sat_inc(m_elapsed);
        if (echo) begin
          m_phase      = RANGER_MEASURE;
          m_echo_width = CNT_W'(1);
          if (past_timeout()) begin
            m_phase  = RANGER_IDLE;
            r.done   = 1'b1;
            r.status = ST_TOO_LONG;
          end
        end else if (past_timeout()) begin
          m_phase  = RANGER_IDLE;
          r.done   = 1'b1;
          r.status = ST_NO_ECHO;
        end
      end
      default: begin
        if (echo) begin
          m_elapsed    = sat_inc(m_elapsed);
          m_echo_width = sat_inc(m_echo_width);
          if (past_timeout()) begin
            m_phase  = RANGER_IDLE;
            r.done   = 1'b1;
            r.status = ST_TOO_LONG;
          end
        end else begin
          scaled      = (64'(m_echo_width) * SCALE_NUM) / SCALE_DEN;
          m_last_dist = (scaled > 64'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(scaled);
          m_phase     = RANGER_IDLE;
          r.done      = 1'b1;
        end
      end
    endcase
    r.busy     = (m_phase != RANGER_IDLE);
    r.distance = m_last_dist;
    pending_ticks.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting and output checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("beat %0d %s got %0h want %0h", out_beats, name, got, want));
  endtask

  // Sample at the falling edge: the beat seen here is the one taken at the
  // next rising edge, and nothing moves in between.
  always @(negedge clk) begin
    tick_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_ticks.size() == 0) begin
        flag_mismatch($sformatf("beat %0d arrived with nothing predicted", out_beats));
      end else begin
        want = pending_ticks.pop_front();
        compare_field("trigger_level", 32'(trigger_level), 32'(want.trig));
        compare_field("busy_res", 32'(busy_res), 32'(want.busy));
        compare_field("done_res", 32'(done_res), 32'(want.done));
        compare_field("status", 32'(status), 32'(want.status));
        compare_field("distance_mm", 32'(distance_mm), 32'(want.distance));
      end
      out_beats++;
    end
  end

  // Receiver: random stalls, plus a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one tick beat and hold it until taken. Entered and left on a
  // rising edge; valid is left high so the next beat can follow back to back.
  task automatic send_tick(input logic echo, input logic start);
    logic taken;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid   <= 1'b1;
    echo_level <= echo;
    start_req  <= start;
    do begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    items_sent++;
    ranger_model_step(echo, start);
  endtask

  // Drop valid, then wait out every predicted beat plus the pipeline depth.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned hold_cycles);
    in_valid <= 1'b0;
    @(negedge clk);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
    hold_request   = hold_cycles;
    @(posedge clk);
  endtask

  // Drive whatever echo ends the measurement in flight quickest.
  task automatic finish_measurement();
    while (m_phase != RANGER_IDLE)
      send_tick(m_phase == RANGER_WAIT_RISE, 1'b0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_TRIGGER_WIDTH) m_trig_width = data[TRIG_WIDTH_BITS-1:0];
    else m_timeout = data[TIMEOUT_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Bring the block to rest, then load both registers. Junk in the unused
  // upper bits of the width write must be dropped.
  task automatic reconfigure(input logic [TRIG_WIDTH_BITS-1:0] width,
                             input logic [TIMEOUT_BITS-1:0] ticks);
    finish_measurement();
    drain_results();
    write_register(REG_TRIGGER_WIDTH,
                   CFG_DATA_BITS'({CFG_DATA_BITS'($urandom) >> TRIG_WIDTH_BITS, width}));
    write_register(REG_TIMEOUT_TICKS, CFG_DATA_BITS'(ticks));
  endtask

  // One measurement: start, trigger, lead ticks of low echo, width ticks of
  // high echo, then a low tick. Noise flips the echo and raises stray starts.
  task automatic run_measurement(input int unsigned lead, input int unsigned width,
                                 input int unsigned noise_pct);
    int unsigned i;
    send_tick(1'($urandom_range(1)), 1'b1);
    while (m_phase == RANGER_TRIGGER)
      send_tick(1'($urandom_range(1)), $urandom_range(99) < noise_pct);
    for (i = 0; i < lead && m_phase == RANGER_WAIT_RISE; i++)
      send_tick($urandom_range(99) < noise_pct, $urandom_range(99) < noise_pct);
    for (i = 0; i < width && m_phase != RANGER_IDLE; i++)
      send_tick(!($urandom_range(99) < noise_pct), $urandom_range(99) < noise_pct);
    if (m_phase == RANGER_MEASURE)
      send_tick(1'b0, $urandom_range(99) < noise_pct);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: width 10, long timeout; short echo gives a small distance.
  task automatic test_reset_defaults();
    run_measurement(2, 12, 0);
  endtask

  task automatic test_directed_corners();
    // Zero width acts as one tick, zero timeout as one tick.
    reconfigure(8'd0, '0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);          // trigger ends, echo ignored
    send_tick(1'b0, 1'b0);          // no rise before timeout
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);          // rise already past timeout; start dropped
    send_tick(1'b1, 1'b0);          // idle, echo high does nothing
    // Short timeout: echo too long, then a good echo with stray starts.
    reconfigure(8'd2, 23'd3);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);          // start while busy in trigger
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);          // timeout while measuring
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);          // rise, start while busy
    send_tick(1'b0, 1'b1);          // fall finishes ok; start on that tick dropped
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_extreme_settings();
    set_idling(0, 0, 0);
    reconfigure(8'd255, {TIMEOUT_BITS{1'b1}});
    run_measurement(5, 100, 0);
    reconfigure(8'd1, 23'd1);
    run_measurement(0, 1, 0);       // rise on the first wait tick times out
    run_measurement(1, 1, 0);       // no rise
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    int unsigned goal;
    int unsigned next_cfg;
    int unsigned pick;
    logic [TRIG_WIDTH_BITS-1:0] width;
    logic [TIMEOUT_BITS-1:0] ticks;
    set_idling(send_pct, recv_pct, 0);
    goal = items_sent + n_items;
    next_cfg = items_sent;
    while (items_sent < goal) begin
      if (items_sent >= next_cfg) begin
        pick = $urandom_range(99);
        width = (pick < 5) ? 8'd0 : (pick < 10) ? 8'($urandom_range(100, 255))
                                                : 8'($urandom_range(1, 12));
        pick = $urandom_range(99);
        ticks = (pick < 5) ? '0 : (pick < 75) ? 23'($urandom_range(1, 40))
                                              : 23'($urandom_range(41, 300));
        reconfigure(width, ticks);
        next_cfg = items_sent + 120;
      end
      if ($urandom_range(99) < 15) begin
        // Noise: loose ticks, some with stray starts.
        repeat ($urandom_range(1, 4))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        run_measurement($urandom_range(0, m_timeout + 2), $urandom_range(1, m_timeout + 2),
                        ($urandom_range(99) < 20) ? 10 : 0);
      end
    end
  endtask

  // Hold the output off for a long stretch while ticks keep coming, so the
  // queue fills and in_ready drops; then pause until everything is out.
  task automatic test_backpressure();
    int unsigned goal;
    reconfigure(8'd3, 23'd50);
    set_idling(0, 0, 300);
    goal = items_sent + 120;
    while (items_sent < goal)
      run_measurement($urandom_range(0, 20), $urandom_range(1, 40), 0);
    drain_results();
    set_idling(0, 0, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_corners();
    test_extreme_settings();
    test_random_traffic(0, 0, 100);
    test_random_traffic(86, 0, 100);
    test_random_traffic(0, 86, 100);
    test_random_traffic(25, 25, 100);
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk);
    if (pending_ticks.size() != 0)
      flag_mismatch($sformatf("%0d predicted beats never arrived", pending_ticks.size()));
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
